// ===== sv/gvn_pkg.sv =====
// gvn_pkg: shared types and constants of the grid vertex normal block.
// Used by the vertex store, the multiply-accumulate unit, the top level and the checker.
package gvn_pkg;

  // Grid geometry
  localparam int MAX_GRID = 63;
  localparam int SIDE     = MAX_GRID + 1;
  localparam int DEPTH    = SIDE * SIDE;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int IDX_W    = 6;
  localparam int GRID_RST = 10;

  // Data widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NORM_W  = 51;

  // Sequencer lengths
  localparam int NUM_READS = 4;
  localparam int NUM_STEPS = 6;
  localparam int CNT_W     = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_NORMAL = 1'b1
  } op_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic signed [DIFF_W-1:0] z;
  } diff_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] x;
    logic signed [NORM_W-1:0] y;
    logic signed [NORM_W-1:0] z;
  } acc_t;

  // Cross product steps of u x v, one product each
  typedef enum logic [CNT_W-1:0] {
    ST_X_POS = 3'd0,  // + uy*vz
    ST_X_NEG = 3'd1,  // - uz*vy
    ST_Y_POS = 3'd2,  // + uz*vx
    ST_Y_NEG = 3'd3,  // - ux*vz
    ST_Z_POS = 3'd4,  // + ux*vy
    ST_Z_NEG = 3'd5   // - uy*vx
  } step_e;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic  clear;
    logic  issue;
    step_e step;
  } mac_ctrl_t;

endpackage

// ===== sv/gvn_store.sv =====
// gvn_store: single-port vertex memory, one write or one read per cycle.
// Read data is registered. Depends on gvn_pkg.
module gvn_store (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [gvn_pkg::ADDR_W-1:0] addr_i,
  input  gvn_pkg::vertex_t      wdata_i,
  output gvn_pkg::vertex_t      rdata_o
);
  import gvn_pkg::*;

  vertex_t mem [DEPTH];
  vertex_t rdata_q;

  // Read-first single port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/gvn_mac.sv =====
// gvn_mac: shared 25x25 multiplier with registered product and three accumulators.
// Works through u x v one product per step. Depends on gvn_pkg.
module gvn_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gvn_pkg::mac_ctrl_t ctrl_i,
  input  gvn_pkg::diff_t     u_i,
  input  gvn_pkg::diff_t     v_i,
  output gvn_pkg::acc_t      acc_o
);
  import gvn_pkg::*;

  logic signed [DIFF_W-1:0] opa, opb;
  logic signed [PROD_W-1:0] prod_q;
  logic                     pend_q;
  step_e                    pstep_q;
  acc_t                     acc_q, acc_d;
  logic signed [NORM_W-1:0] prod_ext;

  // Operand select per step
  always_comb begin
    unique case (ctrl_i.step)
      ST_X_POS: begin opa = u_i.y; opb = v_i.z; end
      ST_X_NEG: begin opa = u_i.z; opb = v_i.y; end
      ST_Y_POS: begin opa = u_i.z; opb = v_i.x; end
      ST_Y_NEG: begin opa = u_i.x; opb = v_i.z; end
      ST_Z_POS: begin opa = u_i.x; opb = v_i.y; end
      ST_Z_NEG: begin opa = u_i.y; opb = v_i.x; end
      default:  begin opa = '0;    opb = '0;    end
    endcase
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q  <= opa * opb;
      pstep_q <= ctrl_i.step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= ctrl_i.issue;
    end
  end

  assign prod_ext = {{(NORM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  // Accumulate the previous step's product
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (pend_q) begin
      unique case (pstep_q)
        ST_X_POS: acc_d.x = acc_q.x + prod_ext;
        ST_X_NEG: acc_d.x = acc_q.x - prod_ext;
        ST_Y_POS: acc_d.y = acc_q.y + prod_ext;
        ST_Y_NEG: acc_d.y = acc_q.y - prod_ext;
        ST_Z_POS: acc_d.z = acc_q.z + prod_ext;
        ST_Z_NEG: acc_d.z = acc_q.z - prod_ext;
        default:  acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

// ===== sv/grid_vertex_normal.sv =====
// grid_vertex_normal: vertex grid store with normal estimation at one point.
// Instantiates gvn_store and gvn_mac; depends on gvn_pkg.
//
//   channel | direction | handshake             | beat
//   in      | to block  | in_valid_i/in_stall_o | op, row, col, vx, vy, vz
//   out     | from block| out_valid_o/out_stall_i| normal_x/y/z, index_error
//   cfg     | to block  | cfg_we_i              | grid_size
//
// A write beat leaves the block idle; writes can follow each other every cycle.
// A compute beat holds the input through the accept, four reads from the
// single store port plus the wait for the last read data, six products through the
// one shared multiplier, one drain and one load, which waits for a free output register.
// The sum of the four cross products equals (A-C) x (B-D), so P is not read.
// An out-of-range compute goes straight to the load. Reset clears control only; the store
// has no clearing pass. A stalled result holds in the output register.
module grid_vertex_normal (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gvn_pkg::IDX_W-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [gvn_pkg::IDX_W-1:0]   row_i,
  input  logic [gvn_pkg::IDX_W-1:0]   col_i,
  input  logic signed [gvn_pkg::COORD_W-1:0] vx_i,
  input  logic signed [gvn_pkg::COORD_W-1:0] vy_i,
  input  logic signed [gvn_pkg::COORD_W-1:0] vz_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [gvn_pkg::NORM_W-1:0] normal_x_o,
  output logic signed [gvn_pkg::NORM_W-1:0] normal_y_o,
  output logic signed [gvn_pkg::NORM_W-1:0] normal_z_o,
  output logic                        index_error_o
);
  import gvn_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_MUL   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [IDX_W-1:0]     grid_q;
  logic [IDX_W-1:0]     row_q, col_q;
  logic                 bad_q;
  vertex_t              tmp_q;
  diff_t                u_q, v_q;
  logic                 out_valid_q;
  logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
  logic                 err_q;

  logic [IDX_W-1:0]     n, rp, rn, cp, cn;
  logic                 in_acc, in_bad, out_free, load;
  logic                 st_we;
  logic [ADDR_W-1:0]    st_addr;
  vertex_t              st_rdata;
  mac_ctrl_t            mac_ctrl;
  acc_t                 acc;

  function automatic logic [ADDR_W-1:0] vaddr(input logic [IDX_W-1:0] r,
                                               input logic [IDX_W-1:0] c);
    vaddr = ADDR_W'(int'(r) * SIDE + int'(c));
  endfunction

  function automatic diff_t vsub(input vertex_t a, input vertex_t b);
    diff_t d;
    d.x = {a.x[COORD_W-1], a.x} - {b.x[COORD_W-1], b.x};
    d.y = {a.y[COORD_W-1], a.y} - {b.y[COORD_W-1], b.y};
    d.z = {a.z[COORD_W-1], a.z} - {b.z[COORD_W-1], b.z};
    vsub = d;
  endfunction

  // Grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= IDX_W'(GRID_RST);
    end else if (cfg_we_i) begin
      grid_q <= cfg_wdata_i;
    end
  end

  // Effective size and wrapped neighbour indices
  assign n  = (grid_q > IDX_W'(MAX_GRID)) ? IDX_W'(MAX_GRID) : grid_q;
  assign rp = (row_q == '0) ? n  : row_q - 1'b1;
  assign rn = (row_q == n)  ? '0 : row_q + 1'b1;
  assign cp = (col_q == '0) ? n  : col_q - 1'b1;
  assign cn = (col_q == n)  ? '0 : col_q + 1'b1;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_bad     = (row_i > n) || (col_i > n);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = (state_q == S_DONE) && out_free;

  // Store port: input address while idle, neighbour sweep while reading
  assign st_we = in_acc && (op_i == OP_WRITE) && !in_bad;
  always_comb begin
    st_addr = vaddr(row_i, col_i);
    if (state_q == S_READ) begin
      unique case (cnt_q)
        3'd0:    st_addr = vaddr(rp, col_q);
        3'd1:    st_addr = vaddr(rn, col_q);
        3'd2:    st_addr = vaddr(row_q, cn);
        3'd3:    st_addr = vaddr(row_q, cp);
        default: st_addr = vaddr(row_q, col_q);
      endcase
    end
  end

  gvn_store u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .addr_i  (st_addr),
    .wdata_i ({vx_i, vy_i, vz_i}),
    .rdata_o (st_rdata)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (op_i == OP_NORMAL)) begin
          state_d = in_bad ? S_DONE : S_READ;
          cnt_d   = '0;
        end
      end
      S_READ: begin
        if (cnt_q == CNT_W'(NUM_READS)) begin
          state_d = S_MUL;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        if (cnt_q == CNT_W'(NUM_STEPS - 1)) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: state_d = S_DONE;
      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Latch the point; gather u = A - C and v = B - D as reads return
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= row_i;
      col_q <= col_i;
      bad_q <= in_bad;
    end
    if (state_q == S_READ) begin
      unique case (cnt_q)
        3'd1:    tmp_q <= st_rdata;
        3'd2:    u_q   <= vsub(tmp_q, st_rdata);
        3'd3:    tmp_q <= st_rdata;
        3'd4:    v_q   <= vsub(tmp_q, st_rdata);
        default: ;
      endcase
    end
  end

  // Shared multiplier steps
  always_comb begin
    mac_ctrl.clear = in_acc;
    mac_ctrl.issue = (state_q == S_MUL);
    mac_ctrl.step  = step_e'(cnt_q);
  end

  gvn_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .u_i    (u_q),
    .v_i    (v_q),
    .acc_o  (acc)
  );

  // Output register, quarter by arithmetic shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      err_q <= bad_q;
      if (bad_q) begin
        nx_q <= '0;
        ny_q <= '0;
        nz_q <= '0;
      end else begin
        nx_q <= {{2{acc.x[NORM_W-1]}}, acc.x[NORM_W-1:2]};
        ny_q <= {{2{acc.y[NORM_W-1]}}, acc.y[NORM_W-1:2]};
        nz_q <= {{2{acc.z[NORM_W-1]}}, acc.z[NORM_W-1:2]};
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign normal_x_o    = nx_q;
  assign normal_y_o    = ny_q;
  assign normal_z_o    = nz_q;
  assign index_error_o = err_q;

endmodule

// ===== sv/gvn_checker.sv =====
// gvn_checker: port-level assertions for grid_vertex_normal, attached by bind.
// Depends on gvn_pkg.
module gvn_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        op_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [gvn_pkg::NORM_W-1:0] normal_x_o,
  input logic signed [gvn_pkg::NORM_W-1:0] normal_y_o,
  input logic signed [gvn_pkg::NORM_W-1:0] normal_z_o,
  input logic                        index_error_o
);
  import gvn_pkg::*;

  // No result shows in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A compute beat makes the block busy
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_NORMAL) |=> in_stall_o)
    else $error("compute beat did not occupy the block");

  // A write beat leaves the block ready
  a_write_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (op_i == OP_WRITE) |=> !in_stall_o)
    else $error("write beat stalled the input");

  // Error results carry a zero normal
  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |->
      (normal_x_o == '0) && (normal_y_o == '0) && (normal_z_o == '0))
    else $error("index error with non-zero normal");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(normal_x_o) && $stable(normal_y_o) &&
      $stable(normal_z_o) && $stable(index_error_o))
    else $error("stalled result changed");

endmodule

bind grid_vertex_normal gvn_checker u_gvn_checker (.*);
